FILE: hdl/kcl_pkg.sv
// ----------------------------------------------------------------------------
// Keypad code lock package
// Mode codes, result status codes and the result item type shared by the
// keypad code lock controller.
// ----------------------------------------------------------------------------
package kcl_pkg;

    // Width and ceiling of the consecutive failure count.
    localparam int FAIL_BITS = 4;
    localparam logic [FAIL_BITS-1:0] FAIL_MAX = 4'd15;

    // Width and reset value of the failure limit register.
    localparam int LIMIT_BITS = 4;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 4'd5;

    // Configuration register index of the failure limit.
    localparam logic REG_FAILURE_LIMIT = 1'b0;

    // Operating mode, one-hot.
    typedef enum logic [2:0] {
        MODE_NEW     = 3'b001,
        MODE_CONFIRM = 3'b010,
        MODE_CHECK   = 3'b100
    } mode_t;

    // Status reported with every key.
    typedef enum logic [2:0] {
        ST_COLLECT  = 3'd0,
        ST_AGAIN    = 3'd1,
        ST_SET      = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_UNLOCK   = 3'd4,
        ST_WRONG    = 3'd5,
        ST_ALARM    = 3'd6
    } status_t;

    // One result item.
    typedef struct packed {
        status_t              status;
        logic [FAIL_BITS-1:0] failures;
    } result_t;

endpackage

FILE: hdl/keypad_code_lock_controller.sv
// ----------------------------------------------------------------------------
// Keypad code lock controller
// Collects a code twice, stores it on a match, then checks entries against
// it and counts consecutive failures up to a configurable alarm limit.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one key per item (s_key_value); the m_ channel
// returns one result item per key (m_status, m_failures). Both channels use
// valid/ready handshakes.
// Each key is handled in the cycle it is accepted: the mode, key position,
// running match flag, failure count and code store update at that edge and
// the result is registered, in the skid register when the main one stalls.
// One key can be accepted every cycle while the skid register is empty.
// The output side holds a main register and a skid register, so one more key
// is taken while a result waits; s_ready drops only when both are full.
// The code store needs no clearing: it is compared only after six keys of a
// new code have been written. In check mode the code is never rewritten, so
// the first entry itself serves as the stored code.
// Reset (aresetn low, synchronous) returns to new-code mode at key zero with
// a zero failure count, sets the failure limit to 5 and empties the output.
// The failure limit is written through the APB port at byte address 0, by the
// user only while the block is idle (not enforced by it); a zero limit acts as one.
// ----------------------------------------------------------------------------
module keypad_code_lock_controller
    import kcl_pkg::*;
#(
    parameter int CODE_LENGTH = 6,
    parameter int KEY_BITS    = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready,
    // Key input channel
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [KEY_BITS-1:0]  s_key_value,
    // Result channel
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [2:0]           m_status,
    output logic [FAIL_BITS-1:0] m_failures
);

    localparam int POS_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CODE_LENGTH - 1);

    // State
    mode_t                 mode_reg, mode_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic                  match_reg, match_next;
    logic [FAIL_BITS-1:0]  fail_reg, fail_next;
    logic [LIMIT_BITS-1:0] limit_reg;
    logic [KEY_BITS-1:0]   code_reg [CODE_LENGTH];

    // Output buffer
    logic    main_valid_reg, skid_valid_reg;
    result_t main_reg, skid_reg;
    result_t result_next;

    logic s_fire, m_pop;
    logic last_key, key_eq, match_now;
    logic [FAIL_BITS-1:0]  fail_inc;
    logic [LIMIT_BITS-1:0] limit_eff;

    // Configuration port: always ready, limit register readable.
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_FAILURE_LIMIT) ? {{(32-LIMIT_BITS){1'b0}}, limit_reg}
                                                     : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == REG_FAILURE_LIMIT) begin
            limit_reg <= pwdata[LIMIT_BITS-1:0];
        end
    end

    // Handshakes
    assign s_ready = !skid_valid_reg;
    assign s_fire  = s_valid && s_ready;
    assign m_pop   = main_valid_reg && m_ready;

    // Key compare and running match flag.
    assign last_key  = (pos_reg == POS_LAST);
    assign key_eq    = (s_key_value == code_reg[pos_reg]);
    assign match_now = (pos_reg == '0) ? key_eq : (match_reg && key_eq);
    assign fail_inc  = (fail_reg == FAIL_MAX) ? FAIL_MAX : fail_reg + 1'b1;
    assign limit_eff = (limit_reg == '0) ? LIMIT_BITS'(1) : limit_reg;

    // Mode update and result for the key at the input.
    always_comb begin
        mode_next   = mode_reg;
        pos_next    = last_key ? '0 : pos_reg + 1'b1;
        match_next  = match_reg;
        fail_next   = fail_reg;
        result_next.status = ST_COLLECT;
        case (mode_reg)
            MODE_CONFIRM: begin
                match_next = match_now;
                if (last_key) begin
                    match_next = 1'b1;
                    if (match_now) begin
                        mode_next          = MODE_CHECK;
                        result_next.status = ST_SET;
                    end else begin
                        mode_next          = MODE_NEW;
                        result_next.status = ST_MISMATCH;
                    end
                end
            end
            MODE_CHECK: begin
                match_next = match_now;
                if (last_key) begin
                    match_next = 1'b1;
                    if (match_now) begin
                        fail_next          = '0;
                        result_next.status = ST_UNLOCK;
                    end else if (fail_inc >= limit_eff) begin
                        fail_next          = '0;
                        result_next.status = ST_ALARM;
                    end else begin
                        fail_next          = fail_inc;
                        result_next.status = ST_WRONG;
                    end
                end
            end
            default: begin
                // New code entry; unused codes behave the same way.
                match_next = 1'b1;
                if (last_key) begin
                    mode_next          = MODE_CONFIRM;
                    result_next.status = ST_AGAIN;
                end
            end
        endcase
        result_next.failures = fail_next;
    end

    // Control state registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_NEW;
            pos_reg   <= '0;
            match_reg <= 1'b1;
            fail_reg  <= '0;
        end else if (s_fire) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            match_reg <= match_next;
            fail_reg  <= fail_next;
        end
    end

    // Code store: written only while a new code is entered.
    always_ff @(posedge aclk) begin
        if (s_fire && mode_reg != MODE_CONFIRM && mode_reg != MODE_CHECK) begin
            code_reg[pos_reg] <= s_key_value;
        end
    end

    // Output buffer: main register feeds m_, skid register takes an item
    // accepted while the main register is stalled.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (s_fire) begin
            if (!main_valid_reg || m_pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_pop) begin
            main_valid_reg <= skid_valid_reg;
            skid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            if (!main_valid_reg || m_pop) begin
                main_reg <= result_next;
            end else begin
                skid_reg <= result_next;
            end
        end else if (m_pop && skid_valid_reg) begin
            main_reg <= skid_reg;
        end
    end

    assign m_valid    = main_valid_reg;
    assign m_status   = main_reg.status;
    assign m_failures = main_reg.failures;

`ifndef ASSERT_OFF
    // The skid register is used only behind a full main register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> main_valid_reg)
        else $error("skid register holds an item while the main register is empty");

    // Once the code is set the block stays in check mode.
    assert property (@(posedge aclk) disable iff (!aresetn)
        mode_reg == MODE_CHECK |=> mode_reg == MODE_CHECK)
        else $error("left check mode");

    // Alarm and unlock both clear the failure count.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_ALARM || m_status == ST_UNLOCK) |-> m_failures == '0)
        else $error("failure count not cleared on alarm or unlock");

    // The key position wraps within one code.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= POS_LAST)
        else $error("key position beyond code length");
`endif

endmodule

FILE: bench/tb_keypad_code_lock_controller.sv
// ----------------------------------------------------------------------------
// Keypad code lock controller testbench
// Sends keys through the s_ channel, rewrites the failure limit over APB
// between phases and checks every m_ result item against a cycle-free
// model of the lock that the bench keeps alongside the block. A short
// scripted part covers code entry and both kinds of confirm mismatch;
// random phases then walk through new codes, confirms, correct entries,
// wrong entries and alarms under several limits and random backpressure.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock_controller;
    import kcl_pkg::*;

    localparam int CODE_LEN = 6;
    localparam int KEY_W = 4;
    localparam int PHASES = 8;
    localparam int PHASE_KEYS = 190;
    localparam int STALL_LIMIT = 2000;
    localparam logic [2:0] LIMIT_ADDR = {REG_FAILURE_LIMIT, 2'b00};

    // One scripted key: the expected result is given where typed is set.
    typedef struct packed {
        logic [KEY_W-1:0]     key;
        logic                 typed;
        status_t              status;
        logic [FAIL_BITS-1:0] fails;
    } script_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 psel = 1'b0;
    logic                 penable = 1'b0;
    logic                 pwrite = 1'b0;
    logic [2:0]           paddr = '0;
    logic [31:0]          pwdata = '0;
    logic [31:0]          prdata;
    logic                 pready;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic [KEY_W-1:0]     s_key_value = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [2:0]           m_status;
    logic [FAIL_BITS-1:0] m_failures;

    // Lock model state.
    mode_t                 lock_mode;
    int                    lock_pos;
    logic [KEY_W-1:0]      first_keys [CODE_LEN];
    logic [KEY_W-1:0]      code_keys [CODE_LEN];
    logic                  entry_ok;
    logic [FAIL_BITS-1:0]  fail_count;
    logic [LIMIT_BITS-1:0] lock_limit;

    // Plan for the entry now being typed in by the random part.
    logic plan_ok;
    logic plan_noise;
    int   plan_bad_pos;

    result_t awaited_results [$];
    int      error_count = 0;
    int      idle_pct = 20;
    int      pct_match = 50;
    int      pct_correct = 30;
    int      stall_left = 0;
    int      quiet_cycles = 0;

    // Phase settings: failure limit, confirm match rate, correct entry rate
    // and idling rate. The last phase runs with no idling at all.
    int phase_limit   [PHASES] = '{3, 0, 15, 1, 8, 15, 2, 5};
    int phase_match   [PHASES] = '{10, 70, 80, 80, 80, 80, 80, 80};
    int phase_correct [PHASES] = '{30, 30, 4, 30, 35, 3, 25, 30};
    int phase_idle    [PHASES] = '{25, 0, 30, 40, 20, 15, 30, 0};

    // Code entry, confirm with the last key wrong, a second code, then a
    // confirm with the first key wrong. The block ends up in new-code mode.
    script_row_t key_script [24] = '{
        '{4'd0,  1'b1, ST_COLLECT,  4'd0},
        '{4'd15, 1'b1, ST_COLLECT,  4'd0},
        '{4'd0,  1'b1, ST_COLLECT,  4'd0},
        '{4'd15, 1'b1, ST_COLLECT,  4'd0},
        '{4'd10, 1'b1, ST_COLLECT,  4'd0},
        '{4'd5,  1'b1, ST_AGAIN,    4'd0},
        '{4'd0,  1'b1, ST_COLLECT,  4'd0},
        '{4'd15, 1'b1, ST_COLLECT,  4'd0},
        '{4'd0,  1'b1, ST_COLLECT,  4'd0},
        '{4'd15, 1'b1, ST_COLLECT,  4'd0},
        '{4'd10, 1'b1, ST_COLLECT,  4'd0},
        '{4'd6,  1'b1, ST_MISMATCH, 4'd0},
        '{4'd15, 1'b0, ST_COLLECT,  4'd0},
        '{4'd0,  1'b0, ST_COLLECT,  4'd0},
        '{4'd9,  1'b0, ST_COLLECT,  4'd0},
        '{4'd6,  1'b0, ST_COLLECT,  4'd0},
        '{4'd3,  1'b0, ST_COLLECT,  4'd0},
        '{4'd12, 1'b1, ST_AGAIN,    4'd0},
        '{4'd14, 1'b1, ST_COLLECT,  4'd0},
        '{4'd0,  1'b1, ST_COLLECT,  4'd0},
        '{4'd9,  1'b1, ST_COLLECT,  4'd0},
        '{4'd6,  1'b1, ST_COLLECT,  4'd0},
        '{4'd3,  1'b1, ST_COLLECT,  4'd0},
        '{4'd12, 1'b1, ST_MISMATCH, 4'd0}
    };

    keypad_code_lock_controller i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_key_value (s_key_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_status    (m_status),
        .m_failures  (m_failures)
    );

    always #4 aclk = ~aclk;

    // Handle one key in the lock model and return the result it gives.
    function automatic result_t lock_response(input logic [KEY_W-1:0] key);
        result_t               res;
        logic [KEY_W-1:0]      want;
        logic [LIMIT_BITS-1:0] lim;
        int                    pos;
        pos = (lock_pos >= CODE_LEN) ? 0 : lock_pos;
        res.status = ST_COLLECT;
        if (lock_mode == MODE_CONFIRM || lock_mode == MODE_CHECK) begin
            want = (lock_mode == MODE_CONFIRM) ? first_keys[pos] : code_keys[pos];
            entry_ok = (pos == 0) ? (key == want) : (entry_ok && key == want);
        end else begin
            first_keys[pos] = key;
            entry_ok = 1'b1;
        end
        if (pos == CODE_LEN - 1) begin
            lock_pos = 0;
            case (lock_mode)
                MODE_CONFIRM: begin
                    if (entry_ok) begin
                        code_keys = first_keys;
                        lock_mode = MODE_CHECK;
                        res.status = ST_SET;
                    end else begin
                        lock_mode = MODE_NEW;
                        res.status = ST_MISMATCH;
                    end
                end
                MODE_CHECK: begin
                    if (entry_ok) begin
                        fail_count = '0;
                        res.status = ST_UNLOCK;
                    end else begin
                        // A zero limit behaves as a limit of one.
                        lim = (lock_limit == '0) ? LIMIT_BITS'(1) : lock_limit;
                        if (fail_count < FAIL_MAX)
                            fail_count = fail_count + 1'b1;
                        res.status = ST_WRONG;
                        if (fail_count >= lim) begin
                            fail_count = '0;
                            res.status = ST_ALARM;
                        end
                    end
                end
                default: begin
                    lock_mode = MODE_CONFIRM;
                    res.status = ST_AGAIN;
                end
            endcase
            entry_ok = 1'b1;
        end else begin
            lock_pos = pos + 1;
        end
        res.failures = fail_count;
        return res;
    endfunction

    // Pick the next random key. Most entries are well formed: a confirm
    // repeats the first entry and a check repeats the stored code, with
    // one key spoiled when the entry is meant to fail. A few are noise.
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] want;
        if (lock_pos == 0) begin
            plan_ok = ($urandom_range(99) <
                       ((lock_mode == MODE_CONFIRM) ? pct_match : pct_correct));
            plan_bad_pos = $urandom_range(CODE_LEN - 1);
            plan_noise = ($urandom_range(99) < 8);
        end
        if (lock_mode == MODE_NEW || plan_noise)
            return KEY_W'($urandom);
        want = (lock_mode == MODE_CONFIRM) ? first_keys[lock_pos] : code_keys[lock_pos];
        if (!plan_ok && lock_pos == plan_bad_pos)
            want = want ^ KEY_W'($urandom_range(1, 15));
        return want;
    endfunction

    // Offer one key and wait for it to be taken.
    task automatic send_key(input logic [KEY_W-1:0] key, input logic typed,
                            input result_t typed_res);
        result_t res;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_key_value <= key;
        do @(posedge aclk); while (!s_ready);
        res = lock_response(key);
        awaited_results.push_back(typed ? typed_res : res);
    endtask

    // Drop valid for a burst of cycles.
    task automatic hold_off(input int cycles);
        @(negedge aclk);
        s_valid <= 1'b0;
        repeat (cycles - 1) @(negedge aclk);
    endtask

    // Stop sending and wait until every result item has come back.
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_limit(input logic [LIMIT_BITS-1:0] value);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= LIMIT_ADDR;
        pwdata <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        lock_limit = value;
    endtask

    task automatic check_limit(input logic [LIMIT_BITS-1:0] want);
        @(negedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= LIMIT_ADDR;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== 32'(want)) begin
            $error("failure_limit: expected %0d, actual %0d", want, prdata);
            error_count++;
        end
        @(negedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Result side backpressure: m_ready drops in bursts that start at random.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else if ($urandom_range(99) < idle_pct) begin
            m_ready <= 1'b0;
            stall_left = $urandom_range(6);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Compare every result item with the oldest expectation.
    always @(posedge aclk) begin
        result_t exp_res;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                $error("result item with nothing expected: status %0d, failures %0d",
                       m_status, m_failures);
                error_count++;
            end else begin
                exp_res = awaited_results.pop_front();
                if (m_status !== exp_res.status) begin
                    $error("status: expected %0d, actual %0d", exp_res.status, m_status);
                    error_count++;
                end
                if (m_failures !== exp_res.failures) begin
                    $error("failures: expected %0d, actual %0d",
                           exp_res.failures, m_failures);
                    error_count++;
                end
            end
        end
    end

    // Give up when nothing moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        result_t row_res;
        lock_mode = MODE_NEW;
        lock_pos = 0;
        entry_ok = 1'b1;
        fail_count = '0;
        lock_limit = LIMIT_RESET;
        for (int i = 0; i < CODE_LEN; i++) begin
            first_keys[i] = '0;
            code_keys[i] = '0;
        end
        plan_ok = 1'b1;
        plan_noise = 1'b0;
        plan_bad_pos = 0;

        repeat (11) @(negedge aclk);
        aresetn <= 1'b1;
        check_limit(LIMIT_RESET);

        // Scripted keys at the reset limit.
        foreach (key_script[i]) begin
            row_res.status = key_script[i].status;
            row_res.failures = key_script[i].fails;
            if ($urandom_range(99) < idle_pct)
                hold_off($urandom_range(1, 7));
            send_key(key_script[i].key, key_script[i].typed, row_res);
        end

        // Random phases. Each starts with the block idle and every result
        // back, so the sender pauses fully at least once per phase.
        for (int p = 0; p < PHASES; p++) begin
            drain();
            write_limit(LIMIT_BITS'(phase_limit[p]));
            check_limit(LIMIT_BITS'(phase_limit[p]));
            pct_match = phase_match[p];
            pct_correct = phase_correct[p];
            idle_pct = phase_idle[p];
            repeat (PHASE_KEYS) begin
                if ($urandom_range(99) < idle_pct)
                    hold_off($urandom_range(1, 7));
                send_key(random_key(), 1'b0, row_res);
            end
        end

        drain();
        repeat (4) @(posedge aclk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
